FILE: src/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/htbd_pkg.sv
`default_nettype none

package htbd_pkg;

  localparam int NODE_COUNT_DEF   = 512;
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int SYMBOL_BITS_DEF  = 8;

  localparam int SYMBOL_W   = 8;
  localparam int CODEWORD_W = 16;
  localparam int LEN_W      = 5;
  localparam int STATUS_W   = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

endpackage

`default_nettype wire

FILE: src/htbd_node_ram.sv
`default_nettype none

module htbd_node_ram #(
  parameter int DEPTH = htbd_pkg::NODE_COUNT_DEF,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/huffman_tree_bit_decoder.sv
`default_nettype none

// Bit-serial Huffman decoder with a code tree loaded one entry at a time. An item is
// taken when start is high and busy is low; its one result is shown for a single
// cycle with done_o high and cannot be held off, so the receiver must take every beat.
// A decode bit keeps busy high through S_DEC_WALK and S_DEC_CHILD after it is taken
// (two dependent reads of the node memory: the current node, then its child), and its
// result is registered in S_DEC_CHILD; a missing branch is seen after the first read,
// so that bit ends in S_DEC_WALK. An insert of saturated length L keeps busy high in
// S_INS, one tree level per cycle through the memory's single read port, ending early
// when the store fills. A zero-length insert answers on the next edge, never going busy.
// Freshly allocated nodes are written as they are left, and a fill count tracks them,
// so no clearing pass follows reset.
module huffman_tree_bit_decoder #(
  parameter int NODE_COUNT   = htbd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_BITS  = htbd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation_i,
  input  logic [htbd_pkg::SYMBOL_W-1:0]   symbol_i,
  input  logic [htbd_pkg::CODEWORD_W-1:0] codeword_i,
  input  logic [htbd_pkg::LEN_W-1:0]      code_length_i,
  input  logic                            code_bit_i,
  output logic                            done_o,
  output logic                            symbol_valid_o,
  output logic [htbd_pkg::SYMBOL_W-1:0]   decoded_symbol_o,
  output logic [htbd_pkg::STATUS_W-1:0]   status_o
);

  `include "assert_macros.svh"

  localparam int IDX_W     = $clog2(NODE_COUNT);
  localparam int CNT_W     = $clog2(NODE_COUNT + 1);
  localparam int LEN_W     = htbd_pkg::LEN_W;
  localparam int LEN_CMP_W = LEN_W + 1;
  localparam int CW_W      = htbd_pkg::CODEWORD_W;
  localparam int CW_IDX_W  = $clog2(CW_W);
  localparam int SYM_W     = htbd_pkg::SYMBOL_W;
  localparam int SYM_EXT_W = (SYMBOL_BITS > SYM_W) ? SYMBOL_BITS : SYM_W;

  typedef struct packed {
    logic [IDX_W-1:0]       zero_br;
    logic [IDX_W-1:0]       one_br;
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_DEC_WALK,
    S_DEC_CHILD
  } state_e;

  state_e                       state_q, state_d;
  logic [IDX_W-1:0]             cur_q, cur_d;
  logic                         fresh_q, fresh_d;
  logic [LEN_W-1:0]             pos_q, pos_d;
  logic [CW_W-1:0]              code_q, code_d;
  logic [SYMBOL_BITS-1:0]       sym_q, sym_d;
  logic                         bit_q, bit_d;
  logic [CNT_W-1:0]             nodes_used_q, nodes_used_d;
  logic [IDX_W-1:0]             walk_q, walk_d;
  logic                         root_valid_q, root_valid_d;
  logic                         done_q, done_d;
  logic                         sym_valid_q, sym_valid_d;
  logic [SYM_W-1:0]             dsym_q, dsym_d;
  logic [htbd_pkg::STATUS_W-1:0] status_q, status_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [NODE_W-1:0] ram_rdata;
  node_t             ram_wnode;
  node_t             rd_node;
  node_t             cur_node;
  node_t             upd_node;

  logic                 len_over;
  logic [LEN_W-1:0]     len_sat;
  logic [LEN_W-1:0]     bit_pos;
  logic                 ins_bit;
  logic                 walk_bit;
  logic [IDX_W-1:0]     branch;
  logic [SYM_EXT_W-1:0] sym_in_ext;
  logic [SYM_EXT_W-1:0] sym_out_ext;
  logic                 store_full;

  htbd_node_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NODE_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wnode),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_node  = node_t'(ram_rdata);
  assign cur_node = (fresh_q || (cur_q == '0 && !root_valid_q)) ? node_t'('0) : rd_node;

  assign len_over = {1'b0, code_length_i} > LEN_CMP_W'(MAX_CODE_LEN);
  assign len_sat  = len_over ? LEN_W'(MAX_CODE_LEN) : code_length_i;
  assign bit_pos  = pos_q - LEN_W'(1);
  assign ins_bit  = (bit_pos < LEN_W'(CW_W)) ? code_q[bit_pos[CW_IDX_W-1:0]] : 1'b0;
  assign walk_bit = (state_q == S_INS) ? ins_bit : bit_q;
  assign branch   = walk_bit ? cur_node.one_br : cur_node.zero_br;

  assign sym_in_ext  = SYM_EXT_W'(symbol_i);
  assign sym_out_ext = SYM_EXT_W'(rd_node.sym);
  assign store_full  = nodes_used_q == CNT_W'(NODE_COUNT);

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    fresh_d      = fresh_q;
    pos_d        = pos_q;
    code_d       = code_q;
    sym_d        = sym_q;
    bit_d        = bit_q;
    nodes_used_d = nodes_used_q;
    walk_d       = walk_q;
    done_d       = 1'b0;
    sym_valid_d  = sym_valid_q;
    dsym_d       = dsym_q;
    status_d     = status_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_raddr    = cur_q;
    upd_node     = cur_node;
    ram_wnode    = cur_node;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          fresh_d = 1'b0;
          if (operation_i == htbd_pkg::OP_INSERT) begin
            if (code_length_i == '0) begin
              done_d      = 1'b1;
              sym_valid_d = 1'b0;
              dsym_d      = '0;
              status_d    = htbd_pkg::ST_OK;
            end else begin
              state_d   = S_INS;
              cur_d     = '0;
              pos_d     = len_sat;
              code_d    = codeword_i;
              sym_d     = sym_in_ext[SYMBOL_BITS-1:0];
              ram_raddr = '0;
            end
          end else begin
            state_d   = S_DEC_WALK;
            cur_d     = walk_q;
            bit_d     = code_bit_i;
            ram_raddr = walk_q;
          end
        end
      end
      S_INS: begin
        if (pos_q == '0) begin
          upd_node.leaf = 1'b1;
          upd_node.sym  = sym_q;
          ram_we        = 1'b1;
          ram_wnode     = upd_node;
          done_d        = 1'b1;
          sym_valid_d   = 1'b0;
          dsym_d        = '0;
          status_d      = htbd_pkg::ST_OK;
          state_d       = S_IDLE;
        end else if (branch != '0) begin
          ram_raddr = branch;
          cur_d     = branch;
          pos_d     = bit_pos;
        end else if (store_full) begin
          ram_we      = fresh_q;
          done_d      = 1'b1;
          sym_valid_d = 1'b0;
          dsym_d      = '0;
          status_d    = htbd_pkg::ST_FULL;
          state_d     = S_IDLE;
        end else begin
          if (ins_bit) begin
            upd_node.one_br = nodes_used_q[IDX_W-1:0];
          end else begin
            upd_node.zero_br = nodes_used_q[IDX_W-1:0];
          end
          ram_we       = 1'b1;
          ram_wnode    = upd_node;
          cur_d        = nodes_used_q[IDX_W-1:0];
          fresh_d      = 1'b1;
          nodes_used_d = nodes_used_q + CNT_W'(1);
          pos_d        = bit_pos;
        end
      end
      S_DEC_WALK: begin
        if (branch == '0) begin
          done_d      = 1'b1;
          sym_valid_d = 1'b0;
          dsym_d      = '0;
          status_d    = htbd_pkg::ST_MISSING;
          walk_d      = '0;
          state_d     = S_IDLE;
        end else begin
          ram_raddr = branch;
          cur_d     = branch;
          state_d   = S_DEC_CHILD;
        end
      end
      S_DEC_CHILD: begin
        done_d   = 1'b1;
        status_d = htbd_pkg::ST_OK;
        state_d  = S_IDLE;
        if (rd_node.leaf) begin
          sym_valid_d = 1'b1;
          dsym_d      = sym_out_ext[SYM_W-1:0];
          walk_d      = '0;
        end else begin
          sym_valid_d = 1'b0;
          dsym_d      = '0;
          walk_d      = cur_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    root_valid_d = root_valid_q | (ram_we && ram_waddr == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      fresh_q      <= 1'b0;
      pos_q        <= '0;
      code_q       <= '0;
      sym_q        <= '0;
      bit_q        <= 1'b0;
      nodes_used_q <= CNT_W'(1);
      walk_q       <= '0;
      root_valid_q <= 1'b0;
      done_q       <= 1'b0;
      sym_valid_q  <= 1'b0;
      dsym_q       <= '0;
      status_q     <= htbd_pkg::ST_OK;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      fresh_q      <= fresh_d;
      pos_q        <= pos_d;
      code_q       <= code_d;
      sym_q        <= sym_d;
      bit_q        <= bit_d;
      nodes_used_q <= nodes_used_d;
      walk_q       <= walk_d;
      root_valid_q <= root_valid_d;
      done_q       <= done_d;
      sym_valid_q  <= sym_valid_d;
      dsym_q       <= dsym_d;
      status_q     <= status_d;
    end
  end

  assign busy             = state_q != S_IDLE;
  assign done_o           = done_q;
  assign symbol_valid_o   = sym_valid_q;
  assign decoded_symbol_o = dsym_q;
  assign status_o         = status_q;

  `ASSERT_ALWAYS(a_fill_range, clk_i, rst_ni,
    nodes_used_q >= CNT_W'(1) && nodes_used_q <= CNT_W'(NODE_COUNT),
    "node fill count out of range")
  `ASSERT_ALWAYS(a_walk_allocated, clk_i, rst_ni, CNT_W'(walk_q) < nodes_used_q,
    "decode walk points past the allocated nodes")
  `ASSERT_IMPLY(a_done_on_finish, clk_i, rst_ni, $fell(busy), done_o,
    "item finished without a result beat")
  `ASSERT_IMPLY(a_symbol_ok, clk_i, rst_ni, done_o && symbol_valid_o,
    status_o == htbd_pkg::ST_OK, "decoded symbol reported with an error status")

endmodule

`default_nettype wire
